FILE: rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with bulk operations:
// field widths, request mode codes, internal command codes and the command
// beat that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package brf_pkg;

   // Default number of slots in the circular store (one always stays empty).
   localparam int DEPTH_DEF = 64;

   // Entries in the command queue between front and back; a power of two.
   localparam int QDEPTH = 4;

   localparam int MODE_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;
   localparam int FILL_W  = 6;
   // Wide enough for an index or fill plus a count without overflow.
   localparam int SUM_W   = 8;

   // Request mode codes as they arrive on the port.
   localparam logic [MODE_W-1:0] MODE_ENQ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEQ   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DROP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BURST = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ROOM  = 3'd5;

   // Internal operation codes after classification.
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_BAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_ENQ   = 3'd1;
   localparam logic [OP_W-1:0] OP_DEQ   = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK  = 3'd3;
   localparam logic [OP_W-1:0] OP_DROP  = 3'd4;
   localparam logic [OP_W-1:0] OP_BURST = 3'd5;
   localparam logic [OP_W-1:0] OP_ROOM  = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [BYTE_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } cmd_type;

endpackage

FILE: rtl/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// Generic single write port, single read port RAM with a registered read.
// The read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/brf_front.sv
// ----------------------------------------------------------------------------
// brf_front
// Request front end: accepts request beats and classifies the mode into an
// internal operation, unused modes becoming a refused operation.
// ----------------------------------------------------------------------------
module brf_front import brf_pkg::*; (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic [COUNT_W-1:0] req_count,
   output logic               q_valid,
   input  logic               q_ready,
   output cmd_type            q_cmd
);

   logic [OP_W-1:0] op;

   always_comb begin
      case (req_mode)
         MODE_ENQ:   op = OP_ENQ;
         MODE_DEQ:   op = OP_DEQ;
         MODE_PEEK:  op = OP_PEEK;
         MODE_DROP:  op = OP_DROP;
         MODE_BURST: op = OP_BURST;
         MODE_ROOM:  op = OP_ROOM;
         default:    op = OP_BAD;
      endcase
   end

   assign q_cmd.op    = op;
   assign q_cmd.data  = req_data_byte;
   assign q_cmd.count = req_count;
   assign q_valid     = req_valid;
   assign req_ready   = q_ready;

endmodule

FILE: rtl/brf_cmdq.sv
// ----------------------------------------------------------------------------
// brf_cmdq
// Short command queue between the front end and the back end, so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module brf_cmdq import brf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   localparam int PTR_W = $clog2(QDEPTH);
   localparam int CNT_W = $clog2(QDEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

   cmd_type            entry_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push, pop;

   assign in_ready  = (cnt_ff != FULL_CNT);
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

FILE: rtl/brf_back.sv
// ----------------------------------------------------------------------------
// brf_back
// Back end: owns the ring indices, fill count and byte store, and carries out
// one command beat per cycle unless a result stalls in its output register.
// ----------------------------------------------------------------------------
module brf_back import brf_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_data_out,
   output logic               rsp_status,
   output logic [FILL_W-1:0]  rsp_fill_count,
   output logic [FILL_W-1:0]  rsp_space_free,
   output logic               rsp_has_room,
   output logic               rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0] done_ff, done_in;

   logic               o_valid_ff, o_valid_in;
   logic               o_status_ff, o_status_in;
   logic [IDX_W-1:0]   o_fill_ff;
   logic               o_room_ff, o_room_in;
   logic               o_last_ff, o_last_in;
   logic               o_use_ram_ff, o_use_ram_in;

   logic               fire;
   logic               ram_wr_en, ram_rd_en;
   logic [BYTE_W-1:0]  ram_rd_data;
   logic [IDX_W-1:0]   rd_inc, wr_inc, drop_idx;
   logic [SUM_W-1:0]   drop_sum, room_sum;
   logic [COUNT_W-1:0] done_next;
   logic               short;

   assign fire      = cmd_valid && (!o_valid_ff || rsp_ready);
   assign rd_inc    = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
   assign wr_inc    = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
   assign drop_sum  = SUM_W'(rd_idx_ff) + SUM_W'(cmd.count);
   assign drop_idx  = (drop_sum >= DEPTH_SUM) ? IDX_W'(drop_sum - DEPTH_SUM)
                                              : IDX_W'(drop_sum);
   assign room_sum  = SUM_W'(fill_ff) + SUM_W'(cmd.count);
   assign short     = cmd.count > COUNT_W'(fill_ff);
   assign done_next = done_ff + 1'b1;

   always_comb begin
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      fill_in      = fill_ff;
      o_status_in  = 1'b0;
      o_room_in    = 1'b0;
      o_last_in    = 1'b1;
      o_use_ram_in = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      case (cmd.op)
         OP_ENQ: begin
            if (fill_ff == LAST_IDX) begin
               o_status_in = 1'b1;
            end else begin
               ram_wr_en = fire;
               wr_idx_in = wr_inc;
               fill_in   = fill_ff + 1'b1;
            end
         end
         OP_DEQ, OP_PEEK: begin
            if (fill_ff == '0) begin
               o_status_in = 1'b1;
            end else begin
               o_use_ram_in = 1'b1;
               ram_rd_en    = fire;
               if (cmd.op == OP_DEQ) begin
                  rd_idx_in = rd_inc;
                  fill_in   = fill_ff - 1'b1;
               end
            end
         end
         OP_DROP: begin
            if (short) begin
               o_status_in = 1'b1;
            end else begin
               rd_idx_in = drop_idx;
               fill_in   = fill_ff - IDX_W'(cmd.count);
            end
         end
         OP_BURST: begin
            // The length check applies to the first beat only; later beats
            // of an accepted burst always find enough bytes.
            if (done_ff == '0 && short) begin
               o_status_in = 1'b1;
            end else if (cmd.count != '0) begin
               o_use_ram_in = 1'b1;
               ram_rd_en    = fire;
               rd_idx_in    = rd_inc;
               fill_in      = fill_ff - 1'b1;
               o_last_in    = (done_next == cmd.count);
            end
         end
         OP_ROOM: begin
            o_room_in = (room_sum < DEPTH_SUM);
         end
         default: begin
            o_status_in = 1'b1;
         end
      endcase
   end

   assign cmd_pop    = fire && o_last_in;
   assign done_in    = cmd_pop ? '0 : done_next;
   assign o_valid_in = fire || (o_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
         fill_ff    <= '0;
         done_ff    <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
         if (fire) begin
            rd_idx_ff <= rd_idx_in;
            wr_idx_ff <= wr_idx_in;
            fill_ff   <= fill_in;
            done_ff   <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         o_status_ff  <= o_status_in;
         o_fill_ff    <= fill_in;
         o_room_ff    <= o_room_in;
         o_last_ff    <= o_last_in;
         o_use_ram_ff <= o_use_ram_in;
      end
   end

   brf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (cmd.data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   // The RAM read data is held while the result waits, so it is muxed in here.
   assign rsp_valid      = o_valid_ff;
   assign rsp_data_out   = o_use_ram_ff ? ram_rd_data : '0;
   assign rsp_status     = o_status_ff;
   assign rsp_fill_count = FILL_W'(o_fill_ff);
   assign rsp_space_free = FILL_W'(LAST_IDX - o_fill_ff);
   assign rsp_has_room   = o_room_ff;
   assign rsp_last       = o_last_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LAST_IDX)
      else $error("fill count beyond capacity");

   a_fill_fwd: assert property (@(posedge clock) disable iff (reset)
      (wr_idx_ff >= rd_idx_ff) |-> (fill_ff == wr_idx_ff - rd_idx_ff))
      else $error("fill count disagrees with ring indices");

   a_fill_wrap: assert property (@(posedge clock) disable iff (reset)
      (wr_idx_ff < rd_idx_ff) |->
         (fill_ff == IDX_W'(SUM_W'(wr_idx_ff) + DEPTH_SUM - SUM_W'(rd_idx_ff))))
      else $error("fill count disagrees with wrapped ring indices");

   a_hold_read: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !rsp_ready) |-> !ram_rd_en)
      else $error("RAM read issued while a result is stalled");

   a_burst_track: assert property (@(posedge clock) disable iff (reset)
      (done_ff != '0) |-> (cmd_valid && cmd.op == OP_BURST && done_ff < cmd.count))
      else $error("burst beat counter out of step with the command");
`endif

endmodule

FILE: rtl/byte_ring_fifo_with_bulk_ops.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_bulk_ops
// Byte FIFO in a circular store with single, peek, drop, burst and room
// query operations.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH-1 bytes. Enqueue, dequeue, peek, drop and room
// query each give one response beat and run at one request per cycle while
// the response side is not stalled; a burst dequeue of count bytes gives
// count beats, one a cycle while not stalled, set by the single read port of
// the byte store. A refused or zero-count burst gives one beat with last set.
// The first response beat of a request passes through the command queue and
// then the output register of the back end before it is presented. Requests
// are taken into a four entry command queue, so requests keep flowing while
// the response side stalls until that queue is full. The byte store has no
// reset; every byte read back has been written first.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_bulk_ops import brf_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic [COUNT_W-1:0] req_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_data_out,
   output logic               rsp_status,
   output logic [FILL_W-1:0]  rsp_fill_count,
   output logic [FILL_W-1:0]  rsp_space_free,
   output logic               rsp_has_room,
   output logic               rsp_last
);

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    b_valid, b_pop;
   cmd_type b_cmd;

   brf_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .req_count     (req_count),
      .q_valid       (f_valid),
      .q_ready       (f_ready),
      .q_cmd         (f_cmd)
   );

   brf_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (b_valid),
      .out_ready (b_pop),
      .out_cmd   (b_cmd)
   );

   brf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (b_valid),
      .cmd            (b_cmd),
      .cmd_pop        (b_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .rsp_space_free (rsp_space_free),
      .rsp_has_room   (rsp_has_room),
      .rsp_last       (rsp_last)
   );

endmodule
